FILE: sv/wsa_pkg.sv
// ----------------------------------------------------------------------------
// wsa_pkg: shared types and constants for the skinning accumulator
// Field widths, mode codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package wsa_pkg;

    localparam int VertexDepth = 1024;
    localparam int VidxW       = 10;
    localparam int AddrW       = $clog2(VertexDepth);
    localparam int CoefSlots   = 12;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_POS   = 2'd1,
        MODE_NRM   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    // Saturate a 35-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    // Saturate a 50-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

FILE: sv/weighted_skin_accumulate_top.sv
// ----------------------------------------------------------------------------
// weighted_skin_accumulate_top: linear blend skinning accumulator
// Loads joint matrix coefficients, transforms weighted vertices and
// accumulates them into a per-vertex sum store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one command beat: coefficient load,
//   position or normal accumulate, or entry clear (mode in tuser).
//   Master channel m_axis returns the entry's new sum for every accumulate
//   and clear; loads and out-of-range entries return nothing.
//   Throughput: one beat per cycle unless the output stalls. Registers
//   from accept: products, saturated row sum, weight multiply, floored
//   term with read issue, read return, new sum, output; shaped by the two
//   multiplier ranks and the registered accumulator read. Back-to-back
//   hits on one entry are resolved by forwarding the in-flight sum.
//   Reset: a clearing pass sweeps the 1024-entry store, one entry a cycle,
//   so s_axis_tready stays low after reset is released until it ends.
//   Stall: a valid output beat with m_axis_tready low holds the pipeline;
//   nothing is lost or repeated. A skid-free output register drives m_axis.
// ----------------------------------------------------------------------------
module weighted_skin_accumulate_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: coef_index[3:0], coef_value[35:4], vertex_index[45:36],
    //        in_x[77:46], in_y[109:78], in_z[141:110], weight[158:142], pad
    input  logic [159:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_index[9:0], out_x[41:10], out_y[73:42], out_z[105:74], pad
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int AW = wsa_pkg::AddrW;
    localparam int NS = 6;

    // ---- unpack
    wsa_pkg::t_mode     w_mode;
    logic [3:0]         w_slot;
    logic signed [31:0] w_coef, w_x, w_y, w_z;
    logic [9:0]         w_vidx;
    logic [16:0]        w_wt;
    assign w_mode = wsa_pkg::t_mode'(s_axis_tuser);
    assign w_slot = s_axis_tdata[3:0];
    assign w_coef = s_axis_tdata[35:4];
    assign w_vidx = s_axis_tdata[45:36];
    assign w_x    = s_axis_tdata[77:46];
    assign w_y    = s_axis_tdata[109:78];
    assign w_z    = s_axis_tdata[141:110];
    assign w_wt   = s_axis_tdata[158:142];

    // ---- stall control
    logic r_clr_busy;
    logic [AW:0] r_clr_cnt;
    logic w_adv;
    logic r_ov;
    assign w_adv = !r_ov || m_axis_tready;
    assign s_axis_tready = w_adv && !r_clr_busy;

    logic w_acc;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // ---- matrix
    logic signed [31:0] r_mat [wsa_pkg::CoefSlots];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wsa_pkg::CoefSlots; i++) r_mat[i] <= '0;
        end else if (w_acc && w_mode == wsa_pkg::MODE_LOAD
                     && w_slot < 4'(wsa_pkg::CoefSlots)) begin
            r_mat[w_slot] <= w_coef;
        end
    end

    // ---- per-stage control
    typedef struct packed {
        logic       vld;
        logic       clr;
        logic       pos;
        logic [9:0] idx;
        logic       last;
    } t_ctl;
    t_ctl r_c [NS];
    t_ctl w_c0;
    always_comb begin
        w_c0.vld  = w_acc && w_mode != wsa_pkg::MODE_LOAD
                    && 32'(w_vidx) < wsa_pkg::VertexDepth;
        w_c0.clr  = w_mode == wsa_pkg::MODE_CLEAR;
        w_c0.pos  = w_mode == wsa_pkg::MODE_POS;
        w_c0.idx  = w_vidx;
        w_c0.last = s_axis_tlast;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_c[i] <= '0;
        end else if (w_adv) begin
            r_c[0] <= w_c0;
            for (int i = 1; i < NS; i++) r_c[i] <= r_c[i-1];
        end
    end

    // ---- stage 1: products (9 of 32x32), capture weight and translation
    logic signed [63:0] r_p [3][3];
    logic signed [31:0] r_t1 [3];
    logic [16:0]        r_w1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_p[r][0] <= 64'(r_mat[r*4+0]) * 64'(w_x);
                r_p[r][1] <= 64'(r_mat[r*4+1]) * 64'(w_y);
                r_p[r][2] <= 64'(r_mat[r*4+2]) * 64'(w_z);
                r_t1[r]   <= r_mat[r*4+3];
            end
            r_w1 <= w_wt;
        end
    end

    // ---- stage 2: floor and row sum, saturate
    logic signed [31:0] r_row [3];
    logic [16:0]        r_w2;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_row[r] <= wsa_pkg::sat50(50'($signed(r_p[r][0][63:16]))
                    + 50'($signed(r_p[r][1][63:16])) + 50'($signed(r_p[r][2][63:16]))
                    + (r_c[0].pos ? 50'(r_t1[r]) : 50'sd0));
            end
            r_w2 <= r_w1;
        end
    end

    // ---- stage 3: weight multiply
    logic signed [49:0] r_wp [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++)
                r_wp[r] <= 50'(r_row[r]) * $signed({1'b0, r_w2});
        end
    end

    // ---- stage 4: floor weighted term, issue memory read
    logic signed [33:0] r_d4 [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) r_d4[r] <= r_wp[r][49:16];
        end
    end

    // ---- accumulator memory (x,y,z packed)
    logic [95:0] r_mem [wsa_pkg::VertexDepth];
    logic [95:0] r_rd;
    logic        w_we;
    logic [AW-1:0] w_wa;
    logic [95:0] w_wd;
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_adv) r_rd <= r_mem[r_c[3].idx[AW-1:0]];
    end

    // ---- stage 5 register holds term while read returns
    logic signed [33:0] r_d5 [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) for (int r = 0; r < 3; r++) r_d5[r] <= r_d4[r];
    end

    // ---- stage 6: add to old sum with forwarding from the two later writes
    // r_c[4] reads memory data written before its read; the items one and
    // two ahead (r_c[5] and the output reg) may not be in r_rd yet.
    logic [95:0] r_s6;   // result of stage r_c[5]
    logic [95:0] r_wb;   // previous r_s6, the value written before it
    logic [9:0]  r_wb_idx;
    logic        r_wb_vld;
    logic [95:0] w_old, w_new;
    always_comb begin
        w_old = r_rd;
        if (r_wb_vld && r_wb_idx == r_c[4].idx) w_old = r_wb;
        if (r_c[5].vld && r_c[5].idx == r_c[4].idx) w_old = r_s6;
        for (int r = 0; r < 3; r++) begin
            w_new[r*32 +: 32] = r_c[4].clr ? 32'sd0 :
                wsa_pkg::sat35(35'($signed(w_old[r*32 +: 32])) + 35'(r_d5[r]));
        end
    end
    // r_d5 is 34 bits but the floored term fits 33 bits: |row*w|<2^48.

    always_ff @(posedge i_clk) begin
        if (w_adv) r_s6 <= w_new;
    end

    // ---- write port: clear sweep or stage-6 result
    always_comb begin
        if (r_clr_busy) begin
            w_we = 1'b1; w_wa = r_clr_cnt[AW-1:0]; w_wd = '0;
        end else begin
            w_we = w_adv && r_c[5].vld;
            w_wa = r_c[5].idx[AW-1:0];
            w_wd = r_s6;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_wb_vld   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (AW+1)'(wsa_pkg::VertexDepth - 1)) r_clr_busy <= 1'b0;
            end
            if (w_adv) r_wb_vld <= r_c[5].vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wb     <= r_s6;
            r_wb_idx <= r_c[5].idx;
        end
    end

    // ---- output register
    logic [111:0] r_od;
    logic         r_ol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_c[5].vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_od <= {6'd0, r_s6, r_c[5].idx};
            r_ol <= r_c[5].last;
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;

endmodule

FILE: sv/wsa_checker.sv
// ----------------------------------------------------------------------------
// wsa_checker: port-level checks for the skinning accumulator
// Watches the stream ports and flags protocol and pipeline slips.
// ----------------------------------------------------------------------------
module wsa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    // Hold a stalled output beat.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast)) else $error("output beat changed under stall");
    // No input taken while the output is stalled.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during output stall");
    // No output and no input ready right after reset (clearing pass).
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("activity right after reset");
endmodule

bind weighted_skin_accumulate_top wsa_checker u_wsa_checker (.*);

FILE: tb/wsa_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsa_scoreboard: result checker for the skinning accumulator
// Watches both streams, predicts the new entry sum for each accepted
// accumulate or clear beat and compares output beats field by field.
// ----------------------------------------------------------------------------
module wsa_scoreboard (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_sum_beats
);

    typedef struct packed {
        logic [9:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_sum_beat;

    logic signed [31:0] coef_q[wsa_pkg::CoefSlots];
    logic signed [31:0] acc_x[wsa_pkg::VertexDepth];
    logic signed [31:0] acc_y[wsa_pkg::VertexDepth];
    logic signed [31:0] acc_z[wsa_pkg::VertexDepth];
    t_sum_beat          sum_q[$];

    // Floor a Q32.32-scaled value back to Q16.16 (arithmetic shift floors).
    function automatic longint floor16(input longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // One matrix row applied to the source vertex, saturated.
    function automatic longint row_xform(input int row, input longint vx,
                                         input longint vy, input longint vz,
                                         input bit with_trans);
        longint acc;
        acc = floor16(longint'(coef_q[row*4]) * vx)
            + floor16(longint'(coef_q[row*4+1]) * vy)
            + floor16(longint'(coef_q[row*4+2]) * vz);
        if (with_trans) acc += longint'(coef_q[row*4+3]);
        return clamp32(acc);
    endfunction

    function automatic logic signed [31:0] blend(input logic signed [31:0] old,
                                                  input longint t, input longint w);
        return 32'(clamp32(longint'(old) + floor16(t * w)));
    endfunction

    // Predict on accepted command beats.
    always @(posedge i_clk) begin
        wsa_pkg::t_mode     mode;
        logic [3:0]         slot;
        logic [9:0]         vi;
        longint             vx, vy, vz, w;
        bit                 pos;
        t_sum_beat          exp_beat;
        if (!i_rst_n) begin
            foreach (coef_q[k]) coef_q[k] = '0;
            foreach (acc_x[k]) begin
                acc_x[k] = '0; acc_y[k] = '0; acc_z[k] = '0;
            end
            sum_q.delete();
        end else if (s_axis_tvalid && s_axis_tready) begin
            mode = wsa_pkg::t_mode'(s_axis_tuser);
            slot = s_axis_tdata[3:0];
            vi   = s_axis_tdata[45:36];
            if (mode == wsa_pkg::MODE_LOAD) begin
                if (slot < wsa_pkg::CoefSlots) coef_q[slot] = s_axis_tdata[35:4];
            end else if (int'(vi) < wsa_pkg::VertexDepth) begin
                if (mode == wsa_pkg::MODE_CLEAR) begin
                    acc_x[vi] = '0; acc_y[vi] = '0; acc_z[vi] = '0;
                end else begin
                    pos = (mode == wsa_pkg::MODE_POS);
                    vx  = longint'($signed(s_axis_tdata[77:46]));
                    vy  = longint'($signed(s_axis_tdata[109:78]));
                    vz  = longint'($signed(s_axis_tdata[141:110]));
                    w   = longint'(s_axis_tdata[158:142]);
                    acc_x[vi] = blend(acc_x[vi], row_xform(0, vx, vy, vz, pos), w);
                    acc_y[vi] = blend(acc_y[vi], row_xform(1, vx, vy, vz, pos), w);
                    acc_z[vi] = blend(acc_z[vi], row_xform(2, vx, vy, vz, pos), w);
                end
                exp_beat.idx  = vi;
                exp_beat.x    = acc_x[vi];
                exp_beat.y    = acc_y[vi];
                exp_beat.z    = acc_z[vi];
                exp_beat.last = s_axis_tlast;
                sum_q.push_back(exp_beat);
            end
        end
    end

    // Compare each output beat with the oldest expected sum.
    initial begin
        o_fail_count = 0;
        o_sum_beats  = 0;
    end

    always @(posedge i_clk) begin
        t_sum_beat exp_beat, got_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_beat.idx  = m_axis_tdata[9:0];
            got_beat.x    = m_axis_tdata[41:10];
            got_beat.y    = m_axis_tdata[73:42];
            got_beat.z    = m_axis_tdata[105:74];
            got_beat.last = m_axis_tlast;
            o_sum_beats++;
            if (sum_q.size() == 0) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display("%t unexpected beat idx=%0d x=%h y=%h z=%h last=%b", $time,
                             got_beat.idx, got_beat.x, got_beat.y, got_beat.z,
                             got_beat.last);
            end else begin
                exp_beat = sum_q.pop_front();
                if (got_beat !== exp_beat) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%t mismatch exp idx=%0d x=%h y=%h z=%h last=%b / got idx=%0d x=%h y=%h z=%h last=%b",
                                 $time, exp_beat.idx, exp_beat.x, exp_beat.y,
                                 exp_beat.z, exp_beat.last, got_beat.idx,
                                 got_beat.x, got_beat.y, got_beat.z, got_beat.last);
                end
            end
        end
    end

    assign o_pending = sum_q.size();

endmodule

FILE: tb/tb_weighted_skin_accumulate_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_skin_accumulate_top: stimulus for the skinning accumulator
// Loads joint matrices and streams position, normal and clear beats with
// random gaps and output stalls; a scoreboard checks every returned sum.
// ----------------------------------------------------------------------------
module tb_weighted_skin_accumulate_top;

    localparam int CycleLimit = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           sum_beats;
    int           cycle_count;
    bit           quiet;
    int           n_beats;

    weighted_skin_accumulate_top uut (.*);

    wsa_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .s_axis_tlast, .m_axis_tvalid, .m_axis_tready,
        .m_axis_tdata, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending), .o_sum_beats(sum_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort on a hung run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d sums pending", cycle_count, pending);
            $display("weighted_skin_accumulate_top verification failed");
            $finish;
        end
    end

    // Receiver stalls in random bursts, none once quiet.
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        int n;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            m_axis_tready <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: return $urandom;
        endcase
    endfunction

    // Send one beat, waiting for acceptance; maybe idle beforehand.
    task automatic send_beat(input wsa_pkg::t_mode mode, input logic [3:0] slot,
                             input logic [31:0] coef, input logic [9:0] vi,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic [16:0] w,
                             input logic last);
        int n;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {1'b0, w, vz, vy, vx, vi, coef, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_beats++;
    endtask

    task automatic load_coef(input logic [3:0] slot, input logic [31:0] coef);
        send_beat(wsa_pkg::MODE_LOAD, slot, coef, 10'($urandom), $urandom, $urandom,
                  $urandom, 17'($urandom), 1'($urandom));
    endtask

    task automatic vertex_beat(input wsa_pkg::t_mode mode, input logic [9:0] vi,
                               input logic [31:0] vx, input logic [31:0] vy,
                               input logic [31:0] vz, input logic [16:0] w,
                               input logic last);
        send_beat(mode, 4'($urandom), $urandom, vi, vx, vy, vz, w, last);
    endtask

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return 17'd65536;
            1: return 17'h1FFFF;
            2: return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        logic [9:0] base;
        int         len;
        quiet         = 1'b0;
        n_beats       = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = wsa_pkg::MODE_LOAD;
        s_axis_tlast  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity matrix, extremes, weights, clears, ignored slots.
        for (int k = 0; k < wsa_pkg::CoefSlots; k++)
            load_coef(4'(k), (k % 5 == 0) ? 32'h0001_0000 : 32'h0);
        load_coef(4'd15, 32'h7FFF_FFFF);
        load_coef(4'd3, 32'h0002_8000);
        vertex_beat(wsa_pkg::MODE_POS, 10'd0, 32'h0001_0000, 32'h0002_0000,
                    32'hFFFF_0000, 17'd65536, 1'b0);
        vertex_beat(wsa_pkg::MODE_NRM, 10'd0, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 17'd32768, 1'b1);
        vertex_beat(wsa_pkg::MODE_POS, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 17'h1FFFF, 1'b0);
        vertex_beat(wsa_pkg::MODE_POS, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 17'h1FFFF, 1'b1);
        vertex_beat(wsa_pkg::MODE_NRM, 10'd1023, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 17'd0, 1'b0);
        load_coef(4'd0, 32'h8000_0000);
        load_coef(4'd1, 32'h7FFF_FFFF);
        vertex_beat(wsa_pkg::MODE_POS, 10'd5, 32'h8000_0000, 32'h8000_0000, 32'h0,
                    17'd65536, 1'b0);
        vertex_beat(wsa_pkg::MODE_CLEAR, 10'd1023, '0, '0, '0, '0, 1'b1);
        vertex_beat(wsa_pkg::MODE_CLEAR, 10'd5, '1, '1, '1, '1, 1'b0);

        // Hold off until every sum is back.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random: joint lists on small entry windows, hitting hazards often.
        while (n_beats < 760) begin
            for (int k = 0; k < wsa_pkg::CoefSlots; k++)
                if ($urandom_range(0, 2) != 0) load_coef(4'(k), rand_coord());
            if ($urandom_range(0, 7) == 0)
                load_coef(4'($urandom_range(12, 15)), $urandom);
            if (n_beats > 640) quiet = 1'b1;
            base = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 15));
            len  = $urandom_range(1, 24);
            for (int v = 0; v < len; v++) begin
                wsa_pkg::t_mode m;
                case ($urandom_range(0, 9))
                    0: m = wsa_pkg::MODE_CLEAR;
                    1, 2, 3: m = wsa_pkg::MODE_NRM;
                    default: m = wsa_pkg::MODE_POS;
                endcase
                vertex_beat(m, base + 10'($urandom_range(0, 3)), rand_coord(),
                            rand_coord(), rand_coord(), rand_weight(), v == len - 1);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d command beats, checked %0d sum beats", n_beats, sum_beats);
        $display("covered loads, positions, normals, clears, saturation and stalls");
        if (fail_count == 0) begin
            $display("weighted_skin_accumulate_top verification clean");
        end else begin
            $display("weighted_skin_accumulate_top verification failed");
        end
        $finish;
    end

endmodule

FILE: weighted_skin_accumulate_top.f
sv/wsa_pkg.sv
sv/weighted_skin_accumulate_top.sv
sv/wsa_checker.sv
tb/wsa_scoreboard.sv
tb/tb_weighted_skin_accumulate_top.sv
